FILE: sv/feedback_history_interpolator_macros.svh
// Assertion macros shared by the feedback history interpolator RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef FEEDBACK_HISTORY_INTERPOLATOR_MACROS_SVH
`define FEEDBACK_HISTORY_INTERPOLATOR_MACROS_SVH

// Property that an implication holds on every clock edge outside reset.
`define FHI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that a condition never holds outside reset.
`define FHI_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: sv/fhi_pkg.sv
// Package for the feedback history interpolator: sizes, codes and types.
// Depends on nothing.
package fhi_pkg;

    localparam int AxisCountDefault = 6;
    localparam int HistoryDepthDefault = 128;
    localparam int ValueWidth = 32;
    localparam int AxisWidth = 3;
    localparam int StatusWidth = 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [StatusWidth-1:0] STATUS_FOUND = 2'd0;
    localparam logic [StatusWidth-1:0] STATUS_FEW = 2'd1;
    localparam logic [StatusWidth-1:0] STATUS_MISS = 2'd2;

    typedef struct packed {
        logic                         opcode;
        logic [ValueWidth-1:0]        count;
        logic [AxisWidth-1:0]         axis;
        logic [ValueWidth-1:0]        axis_state;
        logic signed [ValueWidth-1:0] position;
        logic signed [ValueWidth-1:0] velocity;
        logic signed [ValueWidth-1:0] torque;
    } in_beat_t;

    typedef struct packed {
        logic [StatusWidth-1:0]       status;
        logic [AxisWidth-1:0]         out_axis;
        logic [ValueWidth-1:0]        out_axis_state;
        logic signed [ValueWidth-1:0] out_position;
        logic signed [ValueWidth-1:0] out_velocity;
        logic signed [ValueWidth-1:0] out_torque;
        logic                         last;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COMMIT,
        ST_STAGE,
        ST_DUP,
        ST_WRITE,
        ST_SCAN,
        ST_CHECK,
        ST_DIV,
        ST_RDAX,
        ST_MUL,
        ST_EMIT,
        ST_FAIL
    } fsm_t;

endpackage

FILE: sv/fhi_if.sv
// Valid/ready channel interface carrying one beat of payload.
// Depends on nothing; the payload type is a parameter.
interface fhi_if #(parameter type payload_t = logic) (input logic clk);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/feedback_history_interpolator.sv
// Top level of the feedback history interpolator: ring memories and sequencer.
// Depends on fhi_pkg, fhi_if and feedback_history_interpolator_macros.svh.
//
// Usage: beats arrive on in_ch (valid/ready). A push beat writes one axis into
// a staging register; the push on the last axis commits the snapshot into the
// ring memories, unless its count equals the newest stored count. A query beat
// walks the ring from oldest to newest through the count memory port, runs a
// 48-step serial divider for the fraction, then reads each axis from the value
// memories and multiplies, giving AXIS_COUNT result beats on out_ch, the last
// one marked by last. A query with fewer than two entries, or with no pair
// bracketing its count, gives one beat with status 1 or 2. One beat is handled
// at a time. When out_ch stalls the result holds in the output register and
// the sequencer waits. Reset clears the ring fill state, the staging snapshot
// and the handshake; stored memory contents are not cleared.
`include "feedback_history_interpolator_macros.svh"
module feedback_history_interpolator
    import fhi_pkg::*;
#(
    parameter int AXIS_COUNT = AxisCountDefault,
    parameter int HISTORY_DEPTH = HistoryDepthDefault
) (
    input logic clk,
    input logic rst_n,
    fhi_if.sink in_ch,
    fhi_if.source out_ch
);
    localparam int SW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
    localparam int MW = $clog2(HISTORY_DEPTH * AXIS_COUNT);
    localparam int AXIS_M1 = AXIS_COUNT - 1;

    logic [ValueWidth-1:0] count_mem [HISTORY_DEPTH];
    logic [ValueWidth-1:0] state_mem [HISTORY_DEPTH*AXIS_COUNT];
    logic [ValueWidth-1:0] pos_mem [HISTORY_DEPTH*AXIS_COUNT];
    logic [ValueWidth-1:0] vel_mem [HISTORY_DEPTH*AXIS_COUNT];
    logic [ValueWidth-1:0] trq_mem [HISTORY_DEPTH*AXIS_COUNT];

    logic [ValueWidth-1:0] stg_state_reg [AXIS_COUNT];
    logic [ValueWidth-1:0] stg_pos_reg [AXIS_COUNT];
    logic [ValueWidth-1:0] stg_vel_reg [AXIS_COUNT];
    logic [ValueWidth-1:0] stg_trq_reg [AXIS_COUNT];

    fsm_t state_reg, state_next;
    logic [SW-1:0] oldest_reg, oldest_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [ValueWidth-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] k_reg, k_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [SW-1:0] s0_reg, s0_next;
    logic [ValueWidth-1:0] c0_reg, c0_next;
    logic [AW-1:0] ax_reg, ax_next;
    logic [5:0] step_reg, step_next;
    logic [47:0] num_reg, num_next;
    logic [32:0] rem_reg, rem_next;
    logic [ValueWidth-1:0] den_reg, den_next;
    logic [16:0] frac_reg, frac_next;
    logic signed [49:0] pp_reg [3];
    logic signed [49:0] pp_next [3];
    logic [ValueWidth-1:0] a_reg [3];
    logic [ValueWidth-1:0] a_next [3];
    logic [ValueWidth-1:0] st_reg, st_next;
    out_beat_t obuf_reg, obuf_next;
    logic ovalid_reg, ovalid_next;

    logic cm_we;
    logic [SW-1:0] cm_addr;
    logic [ValueWidth-1:0] cm_rdata;
    logic vm_we;
    logic [MW-1:0] vm_waddr;
    logic [MW-1:0] vm_raddr;
    logic [ValueWidth-1:0] vm_state, vm_pos, vm_vel, vm_trq;
    logic [SW-1:0] wr_slot;
    logic in_fire;
    logic stg_we;
    logic [32:0] rem_sh;

    function automatic logic [SW-1:0] slot_add(logic [SW-1:0] a, logic [CW-1:0] b);
        logic [CW:0] s;
        s = {{(CW+1-SW){1'b0}}, a} + {1'b0, b};
        if (s >= (CW+1)'(HISTORY_DEPTH)) begin
            s = s - (CW+1)'(HISTORY_DEPTH);
        end
        return s[SW-1:0];
    endfunction

    function automatic logic [MW-1:0] mem_addr(logic [SW-1:0] s, logic [AW-1:0] a);
        return MW'(s * AXIS_COUNT) + MW'(a);
    endfunction

    function automatic logic [49:0] mul_frac(logic [ValueWidth-1:0] a,
                                              logic [ValueWidth-1:0] b,
                                              logic [16:0] f);
        logic signed [32:0] d;
        d = $signed({b[31], b}) - $signed({a[31], a});
        return $signed(d) * $signed({1'b0, f});
    endfunction

    always_ff @(posedge clk)
    begin
        if (cm_we) begin
            count_mem[cm_addr] <= cnt_reg;
        end
        cm_rdata <= count_mem[cm_addr];
    end

    always_ff @(posedge clk)
    begin
        if (vm_we) begin
            state_mem[vm_waddr] <= stg_state_reg[ax_reg];
            pos_mem[vm_waddr] <= stg_pos_reg[ax_reg];
            vel_mem[vm_waddr] <= stg_vel_reg[ax_reg];
            trq_mem[vm_waddr] <= stg_trq_reg[ax_reg];
        end
        vm_state <= state_mem[vm_raddr];
        vm_pos <= pos_mem[vm_raddr];
        vm_vel <= vel_mem[vm_raddr];
        vm_trq <= trq_mem[vm_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < AXIS_COUNT; i++) begin
                stg_state_reg[i] <= '0;
                stg_pos_reg[i] <= '0;
                stg_vel_reg[i] <= '0;
                stg_trq_reg[i] <= '0;
            end
        end else if (stg_we) begin
            stg_state_reg[in_ch.data.axis[AW-1:0]] <= in_ch.data.axis_state;
            stg_pos_reg[in_ch.data.axis[AW-1:0]] <= in_ch.data.position;
            stg_vel_reg[in_ch.data.axis[AW-1:0]] <= in_ch.data.velocity;
            stg_trq_reg[in_ch.data.axis[AW-1:0]] <= in_ch.data.torque;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            oldest_reg <= '0;
            fill_reg <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            oldest_reg <= oldest_next;
            fill_reg <= fill_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        k_reg <= k_next;
        slot_reg <= slot_next;
        s0_reg <= s0_next;
        c0_reg <= c0_next;
        ax_reg <= ax_next;
        step_reg <= step_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        frac_reg <= frac_next;
        st_reg <= st_next;
        obuf_reg <= obuf_next;
        for (int i = 0; i < 3; i++) begin
            pp_reg[i] <= pp_next[i];
            a_reg[i] <= a_next[i];
        end
    end

    assign in_fire = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data = obuf_reg;
    assign wr_slot = (fill_reg >= CW'(HISTORY_DEPTH)) ? oldest_reg : slot_add(oldest_reg, fill_reg);
    assign stg_we = in_fire && (in_ch.data.opcode == OP_PUSH)
        && (in_ch.data.axis < AxisWidth'(AXIS_COUNT));
    assign vm_waddr = mem_addr(slot_reg, ax_reg);
    assign rem_sh = {rem_reg[31:0], num_reg[47]};

    always_comb
    begin
        state_next = state_reg;
        oldest_next = oldest_reg;
        fill_next = fill_reg;
        cnt_next = cnt_reg;
        k_next = k_reg;
        slot_next = slot_reg;
        s0_next = s0_reg;
        c0_next = c0_reg;
        ax_next = ax_reg;
        step_next = step_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        frac_next = frac_reg;
        st_next = st_reg;
        obuf_next = obuf_reg;
        ovalid_next = ovalid_reg;
        for (int i = 0; i < 3; i++) begin
            pp_next[i] = pp_reg[i];
            a_next[i] = a_reg[i];
        end
        cm_we = 1'b0;
        cm_addr = slot_add(oldest_reg, k_reg);
        vm_we = 1'b0;
        vm_raddr = mem_addr(s0_reg, ax_reg);

        if (ovalid_reg && out_ch.ready) begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire) begin
                    cnt_next = in_ch.data.count;
                    k_next = '0;
                    step_next = '0;
                    if (in_ch.data.opcode == OP_QUERY) begin
                        if (fill_reg < CW'(2)) begin
                            st_next = ValueWidth'(STATUS_FEW);
                            state_next = ST_FAIL;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end else if (in_ch.data.axis == AxisWidth'(AXIS_M1)) begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_COMMIT:
            begin
                if (fill_reg == '0) begin
                    state_next = ST_STAGE;
                end else begin
                    cm_addr = slot_add(oldest_reg, fill_reg - CW'(1));
                    state_next = ST_DUP;
                end
            end
            ST_DUP:
            begin
                state_next = (cm_rdata == cnt_reg) ? ST_IDLE : ST_STAGE;
            end
            ST_STAGE:
            begin
                cm_we = 1'b1;
                cm_addr = wr_slot;
                slot_next = wr_slot;
                ax_next = '0;
                if (fill_reg >= CW'(HISTORY_DEPTH)) begin
                    oldest_next = slot_add(oldest_reg, CW'(1));
                end else begin
                    fill_next = fill_reg + CW'(1);
                end
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                vm_we = 1'b1;
                if (ax_reg == AW'(AXIS_M1)) begin
                    state_next = ST_IDLE;
                end else begin
                    ax_next = ax_reg + AW'(1);
                end
            end
            ST_SCAN:
            begin
                if (k_reg >= fill_reg) begin
                    st_next = ValueWidth'(STATUS_MISS);
                    state_next = ST_FAIL;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (k_reg == '0 || c0_reg > cnt_reg) begin
                    c0_next = cm_rdata;
                    s0_next = slot_add(oldest_reg, k_reg);
                    k_next = k_reg + CW'(1);
                    state_next = ST_SCAN;
                end else if (cm_rdata >= cnt_reg) begin
                    den_next = cm_rdata - c0_reg;
                    num_next = {cnt_reg - c0_reg, 16'd0};
                    rem_next = '0;
                    frac_next = '0;
                    step_next = '0;
                    state_next = ST_DIV;
                end else begin
                    c0_next = cm_rdata;
                    s0_next = slot_add(oldest_reg, k_reg);
                    k_next = k_reg + CW'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_DIV:
            begin
                num_next = {num_reg[46:0], 1'b0};
                if (rem_sh >= {1'b0, den_reg}) begin
                    rem_next = rem_sh - {1'b0, den_reg};
                    frac_next = {frac_reg[15:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    frac_next = {frac_reg[15:0], 1'b0};
                end
                if (step_reg == 6'd47) begin
                    if (den_reg == '0) begin
                        frac_next = '0;
                    end
                    ax_next = '0;
                    state_next = ST_RDAX;
                end
                step_next = step_reg + 6'd1;
            end
            ST_RDAX:
            begin
                vm_raddr = mem_addr(slot_add(s0_reg, CW'(1)), ax_reg);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                vm_raddr = mem_addr(s0_reg, ax_reg);
                a_next[0] = vm_pos;
                a_next[1] = vm_vel;
                a_next[2] = vm_trq;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!ovalid_reg) begin
                    pp_next[0] = mul_frac(vm_pos, a_reg[0], frac_reg);
                    pp_next[1] = mul_frac(vm_vel, a_reg[1], frac_reg);
                    pp_next[2] = mul_frac(vm_trq, a_reg[2], frac_reg);
                    st_next = vm_state;
                    for (int i = 0; i < 3; i++) begin
                        a_next[i] = (i == 0) ? vm_pos : (i == 1) ? vm_vel : vm_trq;
                    end
                    state_next = ST_FAIL;
                    step_next = 6'd63;
                end
            end
            ST_FAIL:
            begin
                if (!ovalid_reg || out_ch.ready) begin
                    ovalid_next = 1'b1;
                    if (step_reg == 6'd63) begin
                        obuf_next.status = STATUS_FOUND;
                        obuf_next.out_axis = AxisWidth'(ax_reg);
                        obuf_next.out_axis_state = st_reg;
                        obuf_next.out_position = a_reg[0] + pp_reg[0][47:16];
                        obuf_next.out_velocity = a_reg[1] + pp_reg[1][47:16];
                        obuf_next.out_torque = a_reg[2] + pp_reg[2][47:16];
                        obuf_next.last = (ax_reg == AW'(AXIS_M1));
                        step_next = '0;
                        if (ax_reg == AW'(AXIS_M1)) begin
                            state_next = ST_IDLE;
                        end else begin
                            ax_next = ax_reg + AW'(1);
                            state_next = ST_RDAX;
                        end
                    end else begin
                        obuf_next = '0;
                        obuf_next.status = st_reg[StatusWidth-1:0];
                        obuf_next.last = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `FHI_NEVER(a_fill_max, clk, rst_n, fill_reg > CW'(HISTORY_DEPTH), "fill exceeds depth")
    `FHI_ASSERT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready |=> $stable(obuf_reg), "result changed while stalled")
    `FHI_ASSERT(a_oldest, clk, rst_n, fill_reg < CW'(HISTORY_DEPTH) |-> oldest_reg == '0, "ring moved before full")
    `FHI_NEVER(a_busy, clk, rst_n, in_ch.ready && state_reg != ST_IDLE, "ready while busy")
endmodule

FILE: test/feedback_history_interpolator_tb.sv
// Self-checking testbench for the feedback history interpolator: pushes snapshots,
// queries by tick count and compares every result beat with a behavioral predictor.
// Depends on fhi_pkg, fhi_if and the RTL of feedback_history_interpolator.
module feedback_history_interpolator_tb;
    import fhi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AXES = AxisCountDefault;
    localparam int DEPTH = HistoryDepthDefault;
    localparam int QUERY_CYCLES = 2 * DEPTH + 50 + 4 * AXES;
    localparam longint CYCLE_LIMIT = 1000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fhi_if #(.payload_t(in_beat_t)) in_ch (clk);
    fhi_if #(.payload_t(out_beat_t)) out_ch (clk);

    feedback_history_interpolator u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    always #1 clk = ~clk;

    logic [31:0] hist_count [DEPTH];
    logic [31:0] hist_state [DEPTH][AXES];
    logic signed [31:0] hist_pos [DEPTH][AXES];
    logic signed [31:0] hist_vel [DEPTH][AXES];
    logic signed [31:0] hist_trq [DEPTH][AXES];
    int oldest_slot;
    int fill;
    logic [31:0] stage_state [AXES];
    logic signed [31:0] stage_pos [AXES];
    logic signed [31:0] stage_vel [AXES];
    logic signed [31:0] stage_trq [AXES];

    out_beat_t pending_results [$];
    int errors;
    longint cycles;
    bit tail_phase;
    bit hold_sink;

    task automatic report(input string what, input out_beat_t got, input out_beat_t want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    function automatic logic signed [31:0] interpolate(input logic signed [31:0] a,
                                                       input logic signed [31:0] b,
                                                       input logic [31:0] f);
        logic signed [63:0] p;
        p = (64'(b) - 64'(a)) * $signed({32'd0, f});
        return 32'(64'(a) + (p >>> 16));
    endfunction

    function automatic int slot_at(input int k);
        return (oldest_slot + k) % DEPTH;
    endfunction

    function automatic out_beat_t miss_beat(input logic [1:0] code);
        out_beat_t r;
        r = '0;
        r.status = code;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic expect_result(input out_beat_t r);
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic predict_beat(input in_beat_t b);
        int s;
        int s0;
        int s1;
        logic [31:0] f;
        out_beat_t r;
        if (b.opcode == OP_PUSH) begin
            if (b.axis >= AXES) return;
            stage_state[b.axis] = b.axis_state;
            stage_pos[b.axis] = b.position;
            stage_vel[b.axis] = b.velocity;
            stage_trq[b.axis] = b.torque;
            if (b.axis != AXES - 1) return;
            if (fill > 0 && hist_count[slot_at(fill - 1)] == b.count) return;
            if (fill >= DEPTH) begin
                s = oldest_slot;
                oldest_slot = (oldest_slot + 1) % DEPTH;
            end
            else begin
                s = slot_at(fill);
                fill++;
            end
            hist_count[s] = b.count;
            for (int i = 0; i < AXES; i++) begin
                hist_state[s][i] = stage_state[i];
                hist_pos[s][i] = stage_pos[i];
                hist_vel[s][i] = stage_vel[i];
                hist_trq[s][i] = stage_trq[i];
            end
            return;
        end
        if (fill < 2) begin
            expect_result(miss_beat(STATUS_FEW));
            return;
        end
        for (int k = 0; k + 1 < fill; k++) begin
            s0 = slot_at(k);
            s1 = slot_at(k + 1);
            if (hist_count[s0] <= b.count && hist_count[s1] >= b.count) begin
                f = 0;
                if (hist_count[s1] != hist_count[s0])
                    f = 32'(({32'd0, b.count - hist_count[s0]} << 16)
                            / {32'd0, hist_count[s1] - hist_count[s0]});
                for (int i = 0; i < AXES; i++) begin
                    r.status = STATUS_FOUND;
                    r.out_axis = 3'(i);
                    r.out_axis_state = hist_state[s0][i];
                    r.out_position = interpolate(hist_pos[s0][i], hist_pos[s1][i], f);
                    r.out_velocity = interpolate(hist_vel[s0][i], hist_vel[s1][i], f);
                    r.out_torque = interpolate(hist_trq[s0][i], hist_trq[s1][i], f);
                    r.last = (i == AXES - 1);
                    expect_result(r);
                end
                return;
            end
        end
        expect_result(miss_beat(STATUS_MISS));
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) @(posedge clk);
    endtask

    task automatic offer_beat(input in_beat_t b);
        in_ch.valid <= 1'b1;
        in_ch.data <= b;
        do @(posedge clk); while (!in_ch.ready);
        predict_beat(b);
    endtask

    task automatic maybe_idle;
        if (!tail_phase && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            idle_cycles($urandom_range(1, 18));
        end
    endtask

    task automatic send_beat(input in_beat_t b);
        offer_beat(b);
        maybe_idle();
    endtask

    function automatic in_beat_t push_beat(input logic [31:0] cnt, input int ax);
        in_beat_t b;
        b.opcode = OP_PUSH;
        b.count = cnt;
        b.axis = 3'(ax);
        b.axis_state = $urandom;
        b.position = $urandom;
        b.velocity = $urandom;
        b.torque = $urandom;
        return b;
    endfunction

    function automatic in_beat_t query_beat(input logic [31:0] cnt);
        in_beat_t b;
        b = push_beat(cnt, 0);
        b.opcode = OP_QUERY;
        return b;
    endfunction

    task automatic send_snapshot(input logic [31:0] cnt);
        for (int i = 0; i < AXES; i++) send_beat(push_beat(cnt, i));
    endtask

    task automatic drain;
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    typedef struct {
        in_beat_t beat;
        bit typed;
        out_beat_t want;
    } directed_row_t;

    directed_row_t directed [$];

    task automatic add_row(input in_beat_t b, input bit typed, input out_beat_t want);
        directed_row_t row;
        row.beat = b;
        row.typed = typed;
        row.want = want;
        directed.insert(directed.size(), row);
    endtask

    task automatic run_directed;
        in_beat_t b;
        add_row(query_beat(32'd0), 1, miss_beat(STATUS_FEW));
        b = push_beat(32'd100, AXES - 1);
        b.position = 32'sh7fffffff;
        b.velocity = 32'sh80000000;
        b.torque = 32'sh00010000;
        add_row(b, 0, '0);
        add_row(query_beat(32'hffffffff), 1, miss_beat(STATUS_FEW));
        add_row(push_beat(32'd100, AXES - 1), 0, '0);
        add_row(push_beat(32'd7, 6), 0, '0);
        add_row(push_beat(32'd7, 7), 0, '0);
        for (int i = 0; i < AXES; i++) begin
            b = push_beat(32'd300, i);
            b.position = 32'sh80000000;
            b.velocity = 32'sh7fffffff;
            b.axis_state = 32'hffffffff;
            add_row(b, 0, '0);
        end
        add_row(query_beat(32'd99), 1, miss_beat(STATUS_MISS));
        add_row(query_beat(32'd301), 1, miss_beat(STATUS_MISS));
        add_row(query_beat(32'd100), 0, '0);
        add_row(query_beat(32'd300), 0, '0);
        add_row(query_beat(32'd200), 0, '0);
        add_row(query_beat(32'd101), 0, '0);
        add_row(push_beat(32'hffffffff, AXES - 1), 0, '0);
        add_row(query_beat(32'hfffffffe), 0, '0);
        add_row(query_beat(32'hffffffff), 0, '0);
        foreach (directed[i]) begin
            offer_beat(directed[i].beat);
            if (directed[i].typed) begin
                if (pending_results.size() == 0 || pending_results[$] !== directed[i].want)
                    report("typed row", pending_results.size() ? pending_results[$] : '0,
                           directed[i].want);
            end
            maybe_idle();
        end
    endtask

    task automatic random_phase(input int n_items);
        logic [31:0] base;
        logic [31:0] cnt;
        int sent;
        base = $urandom_range(0, 1000);
        cnt = base;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    cnt = cnt + $urandom_range(0, 3) * ($urandom_range(0, 1) ? 1 : 5000);
                    send_snapshot(cnt);
                    sent += AXES;
                end
                5: begin
                    send_beat(push_beat($urandom, $urandom_range(0, 7)));
                    sent++;
                end
                6: begin
                    send_beat(query_beat($urandom));
                    sent++;
                end
                default: begin
                    send_beat(query_beat(base + $urandom_range(0, cnt - base + 2)));
                    sent++;
                end
            endcase
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        errors = 0;
        tail_phase = 0;
        hold_sink = 0;
        oldest_slot = 0;
        fill = 0;
        for (int i = 0; i < AXES; i++) begin
            stage_state[i] = 0;
            stage_pos[i] = 0;
            stage_vel[i] = 0;
            stage_trq[i] = 0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        drain();
        hold_sink <= 1'b1;
        for (int i = 0; i < 4; i++) send_beat(query_beat(32'd150));
        drain();
        random_phase(80);
        drain();
        for (int i = 0; i < DEPTH + 3; i++)
            send_beat(push_beat(32'(1000 + 10 * i), AXES - 1));
        tail_phase = 1;
        random_phase(70);
        drain();
        idle_cycles(QUERY_CYCLES + 20);
        if (errors == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int hold;
        out_ch.ready = 1'b0;
        wait (rst_n);
        forever begin
            if (hold_sink) begin
                out_ch.ready <= 1'b0;
                hold = 0;
                while (hold < 400) begin
                    @(posedge clk);
                    hold++;
                end
                hold_sink = 0;
            end
            else if (!tail_phase && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                idle_cycles($urandom_range(1, 18));
            end
            else begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        out_beat_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                report("unexpected beat", out_ch.data, '0);
            end
            else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (out_ch.data.status !== want.status) report("status", out_ch.data, want);
                else if (out_ch.data.out_axis !== want.out_axis)
                    report("out_axis", out_ch.data, want);
                else if (out_ch.data.out_axis_state !== want.out_axis_state)
                    report("out_axis_state", out_ch.data, want);
                else if (out_ch.data.out_position !== want.out_position)
                    report("out_position", out_ch.data, want);
                else if (out_ch.data.out_velocity !== want.out_velocity)
                    report("out_velocity", out_ch.data, want);
                else if (out_ch.data.out_torque !== want.out_torque)
                    report("out_torque", out_ch.data, want);
                else if (out_ch.data.last !== want.last) report("last", out_ch.data, want);
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial cycles = 0;
endmodule

FILE: files.f
+incdir+sv
sv/fhi_pkg.sv
sv/fhi_if.sv
sv/feedback_history_interpolator.sv
test/feedback_history_interpolator_tb.sv
